/* hdl/huffman_canonical_code_builder_defines.svh */
// Assertion macros shared by the code builder RTL.
`ifndef HUFFMAN_CANONICAL_CODE_BUILDER_DEFINES_SVH
`define HUFFMAN_CANONICAL_CODE_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HCCB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HCCB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/hccb_pkg.sv */
`default_nettype none
package hccb_pkg;
	localparam int WEIGHT_W = 40;
	localparam int LEN_W    = 6;
	localparam int CODE_W   = 64;
	localparam logic [LEN_W-1:0]    LEN_MAX    = 6'd63;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QRD,
		ST_BCHK,
		ST_SCAN,
		ST_SEND,
		ST_WA,
		ST_WB,
		ST_WN,
		ST_DW,
		ST_DR,
		ST_LW,
		ST_CRD,
		ST_CEND
	} state_t;
endpackage
`default_nettype wire

/* hdl/hccb_in_if.sv */
`default_nettype none
interface hccb_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] frequency;
	logic        last_load;
	logic [7:0]  query_symbol;

	modport source (output valid, cmd, frequency, last_load, query_symbol, input ready);
	modport sink (input valid, cmd, frequency, last_load, query_symbol, output ready);
endinterface
`default_nettype wire

/* hdl/hccb_out_if.sv */
`default_nettype none
interface hccb_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  symbol;
	logic [5:0]  code_length;
	logic [63:0] code;
	logic        table_ready;
	logic        weight_overflow;

	modport source (output valid, symbol, code_length, code, table_ready, weight_overflow,
		input ready);
	modport sink (input valid, symbol, code_length, code, table_ready, weight_overflow,
		output ready);
endinterface
`default_nettype wire

/* hdl/hccb_ram.sv */
`default_nettype none
module hccb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* hdl/huffman_canonical_code_builder.sv */
// Load beat: no result; loads may follow back to back.
// Query beat: tables are read on acceptance and the result is registered in ST_QRD;
// input is held off until the result is taken, so a new query waits for the last one.
// Build after the last load: a check state, then each merge scans the nodes through one
// min-tracking compare unit, a parent walk per symbol then gives its length, and a canonical
// sweep over all lengths follows. No beat is taken meanwhile. Reset clears control state only.
`default_nettype none
`include "huffman_canonical_code_builder_defines.svh"
module huffman_canonical_code_builder #(
	parameter int MAX_SYMBOLS = 256,
	parameter int FREQ_BITS   = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hccb_in_if.sink    req,
	hccb_out_if.source rsp
);
	import hccb_pkg::*;

	localparam int NODES  = 2 * MAX_SYMBOLS - 1;
	localparam int NIDX_W = $clog2(NODES);
	localparam int SYM_W  = $clog2(MAX_SYMBOLS);
	localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
	localparam int QW     = (CNT_W > 8) ? CNT_W : 8;
	localparam int NW     = WEIGHT_W + 1;
	localparam logic [WEIGHT_W-1:0] FREQ_MASK =
		(FREQ_BITS >= WEIGHT_W) ? '1 : ((WEIGHT_W'(1) << FREQ_BITS) - WEIGHT_W'(1));
	localparam logic [CNT_W-1:0] NS_C = CNT_W'(MAX_SYMBOLS);

	state_t state_q, state_d;

	logic [CNT_W-1:0]    n_q, merges_q;
	logic                ready_q, ovf_q, pending_q;
	logic [NIDX_W-1:0]   total_q, scan_q, scan_idx_s1;
	logic                scan_vld_s1;
	logic                m1_ok_q, m2_ok_q;
	logic [WEIGHT_W-1:0] m1w_q, m2w_q;
	logic [NIDX_W-1:0]   m1i_q, m2i_q;
	logic [SYM_W-1:0]    sym_q, cs_q, can_sym_s1;
	logic [NIDX_W-1:0]   node_q;
	logic [LEN_W-1:0]    depth_q, len_q, prev_len_q;
	logic                can_vld_s1, first_q;
	logic [CODE_W-1:0]   prev_code_q, code_nx;
	logic [7:0]          qsym_q;
	logic                hit_q;
	logic                out_valid_q;

	logic [NW-1:0]       node_wd, node_rd;
	logic [NIDX_W-1:0]   node_wa;
	logic                node_we;
	logic [NIDX_W-1:0]   par_wa, par_rd, par_ra;
	logic                par_we, par_re;
	logic [LEN_W-1:0]    len_rd;
	logic [SYM_W-1:0]    len_ra;
	logic                len_re;
	logic [CODE_W-1:0]   code_rd;
	logic                code_we, code_re;

	logic                acc, acc_load, acc_query;
	logic [CNT_W-1:0]    n_eff, n_new;
	logic [NIDX_W-1:0]   root;
	logic                more_now, more_next;
	logic [WEIGHT_W:0]   sum_raw;
	logic                sum_sat;
	logic [WEIGHT_W-1:0] sum_w, freq_w, scan_w;
	logic                scan_live, can_hit;

	assign acc       = req.valid && req.ready;
	assign acc_load  = acc && !req.cmd;
	assign acc_query = acc && req.cmd;
	assign n_eff     = pending_q ? '0 : n_q;
	assign n_new     = (n_eff < NS_C) ? n_eff + CNT_W'(1) : n_eff;
	assign root      = total_q - NIDX_W'(1);
	assign more_now  = ({1'b0, merges_q} + (CNT_W+1)'(1)) < {1'b0, n_q};
	assign more_next = ({1'b0, merges_q} + (CNT_W+1)'(2)) < {1'b0, n_q};
	assign sum_raw   = {1'b0, m1w_q} + {1'b0, m2w_q};
	assign sum_sat   = sum_raw[WEIGHT_W];
	assign sum_w     = sum_sat ? WEIGHT_MAX : sum_raw[WEIGHT_W-1:0];
	assign freq_w    = WEIGHT_W'(req.frequency) & FREQ_MASK;
	assign scan_live = node_rd[NW-1];
	assign scan_w    = node_rd[WEIGHT_W-1:0];
	assign can_hit   = can_vld_s1 && (len_rd == len_q);
	assign code_nx   = first_q ? '0 : (prev_code_q + CODE_W'(1)) << (len_q - prev_len_q);

	assign req.ready           = (state_q == ST_IDLE) && !out_valid_q;
	assign rsp.valid           = out_valid_q;

	// Memory port steering
	always_comb begin
		node_we = 1'b0;
		node_wa = total_q;
		node_wd = {1'b1, sum_w};
		par_we  = 1'b0;
		par_wa  = m1i_q;
		unique case (state_q)
			ST_IDLE: begin
				node_we = acc_load && (n_eff < NS_C);
				node_wa = NIDX_W'(n_eff);
				node_wd = {1'b1, freq_w};
			end
			ST_WA: begin
				node_we = 1'b1;
				node_wa = m1i_q;
				node_wd = {1'b0, m1w_q};
				par_we  = 1'b1;
				par_wa  = m1i_q;
			end
			ST_WB: begin
				node_we = 1'b1;
				node_wa = m2i_q;
				node_wd = {1'b0, m2w_q};
				par_we  = 1'b1;
				par_wa  = m2i_q;
			end
			ST_WN: begin
				node_we = 1'b1;
			end
			default: begin
			end
		endcase
		par_re  = (state_q == ST_DW) && (node_q != root);
		par_ra  = node_q;
		len_re  = (state_q == ST_CRD) || acc_query;
		len_ra  = (state_q == ST_CRD) ? cs_q : SYM_W'(req.query_symbol);
		code_re = acc_query;
		code_we = can_hit;
	end

	hccb_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node (
		.clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd),
		.re(state_q == ST_SCAN), .raddr(scan_q), .rdata(node_rd)
	);

	hccb_ram #(.WIDTH(NIDX_W), .DEPTH(NODES)) u_parent (
		.clk(clk), .we(par_we), .waddr(par_wa), .wdata(total_q),
		.re(par_re), .raddr(par_ra), .rdata(par_rd)
	);

	hccb_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SYMBOLS)) u_len (
		.clk(clk), .we(state_q == ST_LW), .waddr(sym_q), .wdata(depth_q),
		.re(len_re), .raddr(len_ra), .rdata(len_rd)
	);

	hccb_ram #(.WIDTH(CODE_W), .DEPTH(MAX_SYMBOLS)) u_code (
		.clk(clk), .we(code_we), .waddr(can_sym_s1), .wdata(code_nx),
		.re(code_re), .raddr(SYM_W'(req.query_symbol)), .rdata(code_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_query) begin
					state_d = ST_QRD;
				end else if (acc_load && req.last_load) begin
					state_d = ST_BCHK;
				end
			end
			ST_QRD:  state_d = ST_IDLE;
			ST_BCHK: state_d = more_now ? ST_SCAN : ST_DW;
			ST_SCAN: begin
				if (scan_q == root) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: state_d = ST_WA;
			ST_WA:   state_d = ST_WB;
			ST_WB:   state_d = ST_WN;
			ST_WN:   state_d = more_next ? ST_SCAN : ST_DW;
			ST_DW:   state_d = (node_q == root) ? ST_LW : ST_DR;
			ST_DR:   state_d = ST_DW;
			ST_LW:   state_d = (CNT_W'(sym_q) == n_q - CNT_W'(1)) ? ST_CRD : ST_DW;
			ST_CRD: begin
				if (CNT_W'(cs_q) == n_q - CNT_W'(1)) begin
					state_d = ST_CEND;
				end
			end
			ST_CEND: state_d = (len_q == LEN_MAX) ? ST_IDLE : ST_CRD;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			merges_q    <= '0;
			ready_q     <= 1'b0;
			ovf_q       <= 1'b0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
			scan_vld_s1 <= 1'b0;
			can_vld_s1  <= 1'b0;
			m1_ok_q     <= 1'b0;
			m2_ok_q     <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == ST_SCAN);
			can_vld_s1  <= (state_q == ST_CRD);
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_QRD) begin
				out_valid_q <= 1'b1;
			end
			if (acc_load) begin
				n_q <= n_new;
				if (pending_q) begin
					pending_q <= 1'b0;
					ready_q   <= 1'b0;
					ovf_q     <= 1'b0;
				end
				merges_q <= '0;
			end
			if (state_q == ST_WN) begin
				merges_q <= merges_q + CNT_W'(1);
				if (sum_sat) begin
					ovf_q <= 1'b1;
				end
			end
			if (state_d == ST_SCAN && state_q != ST_SCAN) begin
				m1_ok_q <= 1'b0;
				m2_ok_q <= 1'b0;
			end else if (scan_vld_s1 && scan_live) begin
				// Strict compare keeps the lower index on equal weights
				if (!m1_ok_q || scan_w < m1w_q) begin
					m1_ok_q <= 1'b1;
					m2_ok_q <= m1_ok_q;
				end else if (!m2_ok_q || scan_w < m2w_q) begin
					m2_ok_q <= 1'b1;
				end
			end
			if (state_q == ST_LW && state_d == ST_CRD) begin
				first_q <= 1'b1;
			end else if (can_hit) begin
				first_q <= 1'b0;
			end
			if (state_q == ST_CEND && state_d == ST_IDLE) begin
				ready_q   <= 1'b1;
				pending_q <= 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_q;
		can_sym_s1  <= cs_q;
		if (acc_load && req.last_load) begin
			total_q <= NIDX_W'(n_new);
		end
		if (acc_query) begin
			qsym_q <= req.query_symbol;
			hit_q  <= ready_q && (QW'(req.query_symbol) < QW'(n_q));
		end
		if (state_q == ST_QRD) begin
			rsp.symbol          <= qsym_q;
			rsp.code_length     <= hit_q ? len_rd : '0;
			rsp.code            <= hit_q ? code_rd : '0;
			rsp.table_ready     <= ready_q;
			rsp.weight_overflow <= ovf_q;
		end
		if (state_d == ST_SCAN && state_q != ST_SCAN) begin
			scan_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_q <= scan_q + NIDX_W'(1);
		end
		if (scan_vld_s1 && scan_live) begin
			if (!m1_ok_q || scan_w < m1w_q) begin
				m2w_q <= m1w_q;
				m2i_q <= m1i_q;
				m1w_q <= scan_w;
				m1i_q <= scan_idx_s1;
			end else if (!m2_ok_q || scan_w < m2w_q) begin
				m2w_q <= scan_w;
				m2i_q <= scan_idx_s1;
			end
		end
		if (state_q == ST_WN) begin
			total_q <= total_q + NIDX_W'(1);
		end
		// Parent walk: one level per read
		if ((state_q == ST_BCHK || state_q == ST_WN) && state_d == ST_DW) begin
			sym_q   <= '0;
			node_q  <= '0;
			depth_q <= '0;
		end else if (state_q == ST_LW && state_d == ST_DW) begin
			sym_q   <= sym_q + SYM_W'(1);
			node_q  <= NIDX_W'(sym_q) + NIDX_W'(1);
			depth_q <= '0;
		end else if (state_q == ST_DR) begin
			node_q <= par_rd;
			if (depth_q != LEN_MAX) begin
				depth_q <= depth_q + LEN_W'(1);
			end
		end
		if (state_q == ST_LW && state_d == ST_CRD) begin
			len_q <= '0;
			cs_q  <= '0;
		end else if (state_q == ST_CEND && state_d == ST_CRD) begin
			len_q <= len_q + LEN_W'(1);
			cs_q  <= '0;
		end else if (state_q == ST_CRD) begin
			cs_q <= cs_q + SYM_W'(1);
		end
		if (can_hit) begin
			prev_code_q <= code_nx;
			prev_len_q  <= len_q;
		end
	end

	`HCCB_ASSERT_IMP(a_scan_needed, state_q == ST_SCAN,
		({1'b0, merges_q} + (CNT_W+1)'(1)) < {1'b0, n_q}, "merge scan past the last merge")
	`HCCB_ASSERT_IMP(a_two_picks, state_q == ST_WA,
		m1_ok_q && m2_ok_q && (m1i_q != m2i_q), "merge lacks two distinct live nodes")
	`HCCB_ASSERT_NXT(a_query_path, acc_query, state_q == ST_QRD && !out_valid_q,
		"query beat did not enter the read state")
	`HCCB_ASSERT_IMP(a_ready_idle, req.ready, state_q == ST_IDLE && !out_valid_q,
		"input taken while busy")
endmodule
`default_nettype wire
